[rtl/cpd_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the packet deframer.
package cpd_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

   // register indexes on the CSR port
   localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
   localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
   localparam logic [1:0] REG_FOOTER_FIRST  = 2'd2;
   localparam logic [1:0] REG_FOOTER_SECOND = 2'd3;

   localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
   localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
   localparam logic [7:0] FOOTER_FIRST_RST  = 8'h0D;
   localparam logic [7:0] FOOTER_SECOND_RST = 8'h0A;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // frame layout: hdr0 hdr1 type len payload... crc ftr0 ftr1
   localparam int TYPE_POS       = 2;
   localparam int LEN_POS        = 3;
   localparam int PAYLOAD_POS    = 4;
   localparam int FRAME_OVERHEAD = 7;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] footer_first;
      logic [7:0] footer_second;
   } cfg_type;

   typedef struct packed {
      logic rx_take;   // input byte transfer
      logic rsp_take;  // result transfer
   } dp_cmd_type;

   typedef struct packed {
      logic close;     // current input byte completes a frame
      logic run;       // that frame yields a payload run
      logic last;      // result on the output is the final one
   } dp_stat_type;

   // CRC-8, MSB first, one byte
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/cpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cpd_ctrl.sv]
// Controller: sequences byte intake, payload fetch and result delivery.
module cpd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  cpd_pkg::dp_stat_type stat,
   output cpd_pkg::dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_RX    = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_tready   = (state_ff == ST_RX);
   assign rsp_tvalid   = (state_ff == ST_SEND);
   assign cmd.rx_take  = req_tready & req_tvalid;
   assign cmd.rsp_take = rsp_tvalid & rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RX: begin
            if (cmd.rx_take && stat.close) begin
               // payload run waits in ST_FETCH for the first RAM read
               state_in = stat.run ? ST_FETCH : ST_SEND;
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (cmd.rsp_take && stat.last) begin
               state_in = ST_RX;
            end
         end
         default: begin
            state_in = ST_RX;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RX;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/cpd_datapath.sv]
// Datapath: frame hunt, buffering, CRC, frame checks and result fields.
module cpd_datapath #(
   parameter int BUFFER_BYTES = 64,
   parameter int MAX_PAYLOAD  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cpd_pkg::cfg_type     cfg,
   input  cpd_pkg::dp_cmd_type  cmd,
   output cpd_pkg::dp_stat_type stat,
   input  logic [7:0]           rx_byte,
   output logic [1:0]           status,
   output logic [7:0]           cmd_type,
   output logic [5:0]           payload_length,
   output logic [7:0]           data_byte,
   output logic [4:0]           byte_index,
   output logic                 last
);

   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int IW = $clog2(MAX_PAYLOAD + 1);

   logic          in_packet_ff;
   logic [CW-1:0] count_ff;
   logic [7:0]    crc_ff;
   logic [7:0]    type_ff;
   logic [7:0]    len_ff;
   logic [7:0]    prev1_ff;
   logic [7:0]    prev2_ff;
   logic [IW-1:0] idx_ff;
   logic [1:0]    status_ff;
   logic          run_ff;

   logic [CW-1:0] count_next;
   logic [9:0]    pos_wide;
   logic [9:0]    len_wide;
   logic          crc_feed_en;
   logic          close;
   logic          len_bad;
   logic          crc_bad;
   logic [IW-1:0] idx_next;
   logic [9:0]    rd_addr_wide;
   logic [7:0]    rd_data;

   assign count_next = count_ff + 1'b1;
   assign pos_wide   = 10'(count_ff);
   assign len_wide   = {2'b00, len_ff};

   assign crc_feed_en = (pos_wide == 10'(cpd_pkg::TYPE_POS)) ||
                        (pos_wide == 10'(cpd_pkg::LEN_POS)) ||
                        ((pos_wide > 10'(cpd_pkg::LEN_POS)) &&
                         (pos_wide <= len_wide + 10'(cpd_pkg::LEN_POS)));

   // previous byte and current byte against the footer
   assign close = in_packet_ff &&
                  (count_next >= CW'(cpd_pkg::FRAME_OVERHEAD)) &&
                  (prev1_ff == cfg.footer_first) && (rx_byte == cfg.footer_second);

   assign len_bad = (len_ff > 8'(MAX_PAYLOAD)) ||
                    ((len_wide + 10'(cpd_pkg::FRAME_OVERHEAD)) != 10'(count_next));
   // on a well-sized frame the CRC byte sits two bytes before the current one
   assign crc_bad = (crc_ff != prev2_ff);

   assign stat.close = close;
   assign stat.run   = !len_bad && !crc_bad && (len_ff != 8'd0);
   assign stat.last  = !run_ff || ({{(10-IW){1'b0}}, idx_ff} == len_wide - 10'd1);

   // read address follows the index that the next cycle will show
   assign idx_next     = cmd.rsp_take ? idx_ff + 1'b1 : idx_ff;
   assign rd_addr_wide = 10'(cpd_pkg::PAYLOAD_POS) + 10'(idx_next);

   cpd_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.rx_take && in_packet_ff),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (rx_byte),
      .rd_addr (rd_addr_wide[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         count_ff     <= '0;
         crc_ff       <= cpd_pkg::CRC_INIT;
      end else if (cmd.rx_take) begin
         if (!in_packet_ff) begin
            if ((count_ff == CW'(0)) && (rx_byte == cfg.header_first)) begin
               count_ff <= CW'(1);
            end else if ((count_ff == CW'(1)) && (rx_byte == cfg.header_second)) begin
               count_ff     <= CW'(2);
               in_packet_ff <= 1'b1;
               crc_ff       <= cpd_pkg::CRC_INIT;
            end else begin
               count_ff <= '0;
            end
         end else if (close || (count_next >= CW'(BUFFER_BYTES))) begin
            // frame done or buffer full: back to hunting
            in_packet_ff <= 1'b0;
            count_ff     <= '0;
            crc_ff       <= cpd_pkg::CRC_INIT;
         end else begin
            count_ff <= count_next;
            if (crc_feed_en) begin
               crc_ff <= cpd_pkg::crc8_feed(crc_ff, rx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rx_take && in_packet_ff) begin
         prev1_ff <= rx_byte;
         prev2_ff <= prev1_ff;
         if (pos_wide == 10'(cpd_pkg::TYPE_POS)) begin
            type_ff <= rx_byte;
         end
         if (pos_wide == 10'(cpd_pkg::LEN_POS)) begin
            len_ff <= rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         status_ff <= cpd_pkg::STATUS_OK;
         idx_ff    <= '0;
      end else if (cmd.rx_take && close) begin
         idx_ff <= '0;
         run_ff <= stat.run;
         if (len_bad) begin
            status_ff <= cpd_pkg::STATUS_LEN_ERR;
         end else if (crc_bad) begin
            status_ff <= cpd_pkg::STATUS_CRC_ERR;
         end else begin
            status_ff <= cpd_pkg::STATUS_OK;
         end
      end else begin
         idx_ff <= idx_next;
      end
   end

   assign status         = status_ff;
   assign cmd_type       = type_ff;
   assign payload_length = run_ff ? len_ff[5:0] : 6'd0;
   assign data_byte      = run_ff ? rd_data : 8'd0;
   assign byte_index     = run_ff ? 5'(idx_ff) : 5'd0;
   assign last           = stat.last;

endmodule

[rtl/crc8_packet_deframer.sv]
// Input bytes: one per cycle while framing; no result for bytes that do not close a frame.
// A closing byte gives a status result in the next cycle, or a payload run after the fetch state,
// then one payload result per cycle while the receiver is ready; input is held off until the last result is taken.
// Rate is set by the single RAM read port that streams the payload out.
// Reset (synchronous, active high): hunt restarts, CSRs go to their defaults;
// the packet buffer is not cleared.
module crc8_packet_deframer #(
   parameter int BUFFER_BYTES = 64,
   parameter int MAX_PAYLOAD  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] status, [9:2] cmd_type, [15:10] payload_length,
                                    // [23:16] data_byte, [28:24] byte_index, [31:29] zero
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cpd_pkg::cfg_type     cfg_ff;
   cpd_pkg::dp_cmd_type  cmd;
   cpd_pkg::dp_stat_type stat;

   logic [1:0] status;
   logic [7:0] cmd_type;
   logic [5:0] payload_length;
   logic [7:0] data_byte;
   logic [4:0] byte_index;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= cpd_pkg::HEADER_FIRST_RST;
         cfg_ff.header_second <= cpd_pkg::HEADER_SECOND_RST;
         cfg_ff.footer_first  <= cpd_pkg::FOOTER_FIRST_RST;
         cfg_ff.footer_second <= cpd_pkg::FOOTER_SECOND_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            cpd_pkg::REG_HEADER_FIRST:  cfg_ff.header_first  <= csr_pwdata[7:0];
            cpd_pkg::REG_HEADER_SECOND: cfg_ff.header_second <= csr_pwdata[7:0];
            cpd_pkg::REG_FOOTER_FIRST:  cfg_ff.footer_first  <= csr_pwdata[7:0];
            cpd_pkg::REG_FOOTER_SECOND: cfg_ff.footer_second <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         cpd_pkg::REG_HEADER_FIRST:  csr_prdata = {24'd0, cfg_ff.header_first};
         cpd_pkg::REG_HEADER_SECOND: csr_prdata = {24'd0, cfg_ff.header_second};
         cpd_pkg::REG_FOOTER_FIRST:  csr_prdata = {24'd0, cfg_ff.footer_first};
         cpd_pkg::REG_FOOTER_SECOND: csr_prdata = {24'd0, cfg_ff.footer_second};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   cpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cpd_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_PAYLOAD  (MAX_PAYLOAD)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .stat           (stat),
      .rx_byte        (req_tdata),
      .status         (status),
      .cmd_type       (cmd_type),
      .payload_length (payload_length),
      .data_byte      (data_byte),
      .byte_index     (byte_index),
      .last           (rsp_tlast)
   );

   assign rsp_tdata = {3'd0, byte_index, data_byte, payload_length, cmd_type, status};

endmodule

[tb/sv/tb_crc8_packet_deframer.sv]
// Self-checking testbench for the CRC-8 packet deframer: directed and random framed traffic against a predictor.
module tb_crc8_packet_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BUF_BYTES   = 64;
   localparam int MAX_PAYLOAD_BYTES = 32;
   localparam int DRAIN_CYCLES      = 40;
   localparam int CYCLE_LIMIT       = 300000;
   localparam int HOLD_CYCLES       = 300;
   localparam int HOLD_SPACING      = 400;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] cmd_type;
      logic [5:0] payload_length;
      logic [7:0] data_byte;
      logic [4:0] byte_index;
      logic       last;
   } deframe_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // [1:0] status, [9:2] cmd_type, [15:10] payload_length,
                                    // [23:16] data_byte, [28:24] byte_index
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // stimulus and prediction state
   logic [7:0]         rx_pending[$];
   deframe_result_type deframed_q[$];
   cpd_pkg::cfg_type   shadow_cfg = '{cpd_pkg::HEADER_FIRST_RST, cpd_pkg::HEADER_SECOND_RST,
                                      cpd_pkg::FOOTER_FIRST_RST, cpd_pkg::FOOTER_SECOND_RST};
   bit                 in_frame   = 1'b0;
   int                 frame_cnt  = 0;
   logic [7:0]         frame_buf [FRAME_BUF_BYTES];
   logic [7:0]         crc_acc    = cpd_pkg::CRC_INIT;

   int  error_count  = 0;
   int  results_seen = 0;
   int  cycle_count  = 0;
   int  hold_left    = 0;
   int  next_hold_at = 25;
   bit  steady       = 1'b0;

   crc8_packet_deframer #(
      .BUFFER_BYTES(FRAME_BUF_BYTES),
      .MAX_PAYLOAD (MAX_PAYLOAD_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // bit-serial form of the CRC-8 update, MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc;
      for (int k = 7; k >= 0; k--) begin
         r = {r[6:0], 1'b0} ^ ((r[7] ^ b[k]) ? cpd_pkg::CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // advances the deframer state by one received byte and queues the results it yields
   task automatic deframe_byte(input logic [7:0] b);
      int                 pos;
      int                 len;
      deframe_result_type res;
      if (!in_frame) begin
         if (frame_cnt == 0 && b == shadow_cfg.header_first) begin
            frame_buf[0] = b;
            frame_cnt = 1;
         end else if (frame_cnt == 1 && b == shadow_cfg.header_second) begin
            frame_buf[1] = b;
            frame_cnt = 2;
            in_frame = 1'b1;
            crc_acc = cpd_pkg::CRC_INIT;
         end else begin
            frame_cnt = 0;
         end
      end else begin
         pos = frame_cnt;
         frame_buf[pos] = b;
         frame_cnt = pos + 1;
         if (pos == cpd_pkg::TYPE_POS || pos == cpd_pkg::LEN_POS ||
             (pos > cpd_pkg::LEN_POS &&
              pos <= cpd_pkg::LEN_POS + int'(frame_buf[cpd_pkg::LEN_POS]))) begin
            crc_acc = crc8_step(crc_acc, b);
         end
         if (frame_cnt >= cpd_pkg::FRAME_OVERHEAD &&
             frame_buf[frame_cnt-2] == shadow_cfg.footer_first &&
             frame_buf[frame_cnt-1] == shadow_cfg.footer_second) begin
            len = int'(frame_buf[cpd_pkg::LEN_POS]);
            res = '0;
            res.cmd_type = frame_buf[cpd_pkg::TYPE_POS];
            res.last = 1'b1;
            if (len > MAX_PAYLOAD_BYTES || len + cpd_pkg::FRAME_OVERHEAD != frame_cnt) begin
               res.status = cpd_pkg::STATUS_LEN_ERR;
               deframed_q.push_back(res);
            end else if (crc_acc != frame_buf[cpd_pkg::PAYLOAD_POS+len]) begin
               res.status = cpd_pkg::STATUS_CRC_ERR;
               deframed_q.push_back(res);
            end else if (len == 0) begin
               res.status = cpd_pkg::STATUS_OK;
               deframed_q.push_back(res);
            end else begin
               for (int i = 0; i < len; i++) begin
                  res.status = cpd_pkg::STATUS_OK;
                  res.payload_length = 6'(len);
                  res.data_byte = frame_buf[cpd_pkg::PAYLOAD_POS+i];
                  res.byte_index = 5'(i);
                  res.last = (i == len - 1);
                  deframed_q.push_back(res);
               end
            end
            in_frame = 1'b0;
            frame_cnt = 0;
            crc_acc = cpd_pkg::CRC_INIT;
         end else if (frame_cnt >= FRAME_BUF_BYTES) begin
            // runaway frame: dropped without a result
            in_frame = 1'b0;
            frame_cnt = 0;
            crc_acc = cpd_pkg::CRC_INIT;
         end
      end
   endtask

   // payload bytes never equal the first footer byte, so frames close where intended
   function automatic logic [7:0] payload_byte();
      logic [7:0] d;
      do d = 8'($urandom); while (d == shadow_cfg.footer_first);
      return d;
   endfunction

   task automatic queue_frame(input logic [7:0] kind, input int len_field, input int body,
                              input bit corrupt, input fill_kind_type fill);
      logic [7:0] crc;
      logic [7:0] d;
      crc = crc8_step(crc8_step(cpd_pkg::CRC_INIT, kind), 8'(len_field));
      rx_pending.push_back(shadow_cfg.header_first);
      rx_pending.push_back(shadow_cfg.header_second);
      rx_pending.push_back(kind);
      rx_pending.push_back(8'(len_field));
      for (int i = 0; i < body; i++) begin
         case (fill)
            FILL_ZERO: d = 8'h00;
            FILL_ONES: d = 8'hFF;
            default:   d = payload_byte();
         endcase
         rx_pending.push_back(d);
         crc = crc8_step(crc, d);
      end
      if (corrupt) begin
         crc ^= 8'($urandom_range(1, 255));
      end
      rx_pending.push_back(crc);
      rx_pending.push_back(shadow_cfg.footer_first);
      rx_pending.push_back(shadow_cfg.footer_second);
   endtask

   // header, then enough bytes to fill the buffer without a footer
   task automatic queue_runaway();
      rx_pending.push_back(shadow_cfg.header_first);
      rx_pending.push_back(shadow_cfg.header_second);
      repeat (FRAME_BUF_BYTES - 2) rx_pending.push_back(payload_byte());
   endtask

   task automatic queue_random_traffic(input int target);
      int added;
      int r;
      int len;
      int body;
      added = 0;
      while (added < target) begin
         r = $urandom_range(0, 99);
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_PAYLOAD_BYTES)
                                           : $urandom_range(0, 6);
         if (r < 72) begin
            queue_frame(8'($urandom), len, len, 1'b0, FILL_RANDOM);
            added += len + cpd_pkg::FRAME_OVERHEAD;
         end else if (r < 82) begin
            queue_frame(8'($urandom), len, len, 1'b1, FILL_RANDOM);
            added += len + cpd_pkg::FRAME_OVERHEAD;
         end else if (r < 88) begin
            if ($urandom_range(0, 1) == 1) begin
               queue_frame(8'($urandom), $urandom_range(MAX_PAYLOAD_BYTES + 1, 255), len,
                           1'b0, FILL_RANDOM);
               body = len;
            end else begin
               body = (len == 0 || $urandom_range(0, 1) == 1) ? len + 1 : len - 1;
               queue_frame(8'($urandom), len, body, 1'b0, FILL_RANDOM);
            end
            added += body + cpd_pkg::FRAME_OVERHEAD;
         end else if (r < 98) begin
            repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom));
         end else begin
            queue_runaway();
         end
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom), value};   // upper bits are not stored
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         cpd_pkg::REG_HEADER_FIRST:  shadow_cfg.header_first  = value;
         cpd_pkg::REG_HEADER_SECOND: shadow_cfg.header_second = value;
         cpd_pkg::REG_FOOTER_FIRST:  shadow_cfg.footer_first  = value;
         cpd_pkg::REG_FOOTER_SECOND: shadow_cfg.footer_second = value;
         default: begin
         end
      endcase
   endtask

   task automatic set_framing(input logic [7:0] h0, input logic [7:0] h1,
                              input logic [7:0] f0, input logic [7:0] f1);
      csr_write(cpd_pkg::REG_HEADER_FIRST, h0);
      csr_write(cpd_pkg::REG_HEADER_SECOND, h1);
      csr_write(cpd_pkg::REG_FOOTER_FIRST, f0);
      csr_write(cpd_pkg::REG_FOOTER_SECOND, f1);
   endtask

   // sampled on the falling edge so that this cycle's transfers have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (rx_pending.size() != 0 || req_tvalid || deframed_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (rx_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= rx_pending.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      deframe_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (deframed_q.size() == 0) begin
               report_mismatch("unexpected result tdata", rsp_tdata, 32'd0);
            end else begin
               want = deframed_q.pop_front();
               if (rsp_tdata[1:0] != want.status)
                  report_mismatch("status", 32'(rsp_tdata[1:0]), 32'(want.status));
               if (rsp_tdata[9:2] != want.cmd_type)
                  report_mismatch("cmd_type", 32'(rsp_tdata[9:2]), 32'(want.cmd_type));
               if (rsp_tdata[15:10] != want.payload_length)
                  report_mismatch("payload_length", 32'(rsp_tdata[15:10]),
                                  32'(want.payload_length));
               if (rsp_tdata[23:16] != want.data_byte)
                  report_mismatch("data_byte", 32'(rsp_tdata[23:16]), 32'(want.data_byte));
               if (rsp_tdata[28:24] != want.byte_index)
                  report_mismatch("byte_index", 32'(rsp_tdata[28:24]),
                                  32'(want.byte_index));
               if (rsp_tlast != want.last)
                  report_mismatch("tlast", 32'(rsp_tlast), 32'(want.last));
            end
            results_seen <= results_seen + 1;
         end
         rsp_tready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 21);
      end
   end

   // long receiver hold-offs so the block backs up into its input
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (results_seen >= next_hold_at) begin
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= results_seen + HOLD_SPACING;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("crc8_packet_deframer regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames, reset framing bytes
      queue_frame(8'h00, 0, 0, 1'b0, FILL_RANDOM);                 // empty payload
      queue_frame(8'hFF, MAX_PAYLOAD_BYTES, MAX_PAYLOAD_BYTES, 1'b0, FILL_ONES);
      queue_frame(8'h00, 1, 1, 1'b0, FILL_ZERO);
      queue_frame(8'h5A, MAX_PAYLOAD_BYTES, MAX_PAYLOAD_BYTES, 1'b0, FILL_ZERO);
      queue_frame(8'h3C, 3, 3, 1'b1, FILL_RANDOM);                 // bad checksum
      queue_frame(8'h81, MAX_PAYLOAD_BYTES + 1, MAX_PAYLOAD_BYTES + 1, 1'b0, FILL_RANDOM);
      queue_frame(8'h7E, 5, 3, 1'b0, FILL_RANDOM);                 // count short of length
      queue_frame(8'h18, 255, 2, 1'b0, FILL_RANDOM);
      // hunt restart: a repeated first header byte is not taken as a new start
      rx_pending.push_back(cpd_pkg::HEADER_FIRST_RST);
      rx_pending.push_back(cpd_pkg::HEADER_FIRST_RST);
      rx_pending.push_back(cpd_pkg::HEADER_SECOND_RST);
      queue_frame(8'h42, 2, 2, 1'b0, FILL_RANDOM);
      rx_pending.push_back(cpd_pkg::HEADER_FIRST_RST);
      rx_pending.push_back(8'h00);
      queue_frame(8'h24, 1, 1, 1'b0, FILL_RANDOM);
      queue_runaway();
      queue_frame(8'hC3, 4, 4, 1'b0, FILL_RANDOM);
      wait_drained();

      queue_random_traffic(8);
      wait_drained();

      set_framing(8'h00, 8'hFF, 8'hFF, 8'h00);
      steady = 1'b1;
      queue_random_traffic(32);
      wait_drained();
      steady = 1'b0;

      set_framing(8'hFF, 8'h00, 8'h00, 8'hFF);
      queue_random_traffic(6);
      wait_drained();

      set_framing(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      queue_random_traffic(6);
      wait_drained();

      if (error_count == 0) begin
         $display("crc8_packet_deframer regression: pass");
      end else begin
         $display("crc8_packet_deframer regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/cpd_pkg.sv
rtl/cpd_ram.sv
rtl/cpd_ctrl.sv
rtl/cpd_datapath.sv
rtl/crc8_packet_deframer.sv
tb/sv/tb_crc8_packet_deframer.sv
